// ----- rtl/core/evr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the Euler rotation datapath.
package evr_pkg;

  localparam int TRIG_W       = 32;
  localparam int ATAN_ENTRIES = 30;
  localparam int NUM_AXES     = 3;
  localparam int FRAC_SHIFT   = 30;

  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  typedef logic signed [TRIG_W-1:0] trig_word_t;

  typedef struct packed {
    trig_word_t cos_v;
    trig_word_t sin_v;
  } trig_t;

  localparam trig_word_t GAIN_Q30    = 32'sh26DD3B6A;
  localparam trig_word_t HALF_PI     = 32'sh40000000;
  localparam trig_word_t NEG_HALF_PI = 32'shC0000000;
  localparam trig_word_t TRIG_BOUND  = 32'sh41000000;

  localparam trig_word_t ATAN_TBL [0:ATAN_ENTRIES-1] = '{
    32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
    32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
    32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2F9,
    32'sh0000517C, 32'sh000028BE, 32'sh0000145F, 32'sh00000A2F, 32'sh00000517,
    32'sh0000028B, 32'sh00000145, 32'sh000000A2, 32'sh00000051, 32'sh00000028,
    32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000002, 32'sh00000001
  };

endpackage

// ----- rtl/core/evr_cordic.sv -----
`timescale 1ns / 1ps
// Pipelined three-lane CORDIC producing cosine and sine of each angle.
module evr_cordic #(
  parameter int ANGLE_WIDTH   = 32,
  parameter int CORDIC_STAGES = 24,
  parameter int SIDE_W        = 96
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 en,
  input  logic                                                 vld_i,
  input  logic [evr_pkg::NUM_AXES-1:0][ANGLE_WIDTH-1:0]        angle_i,
  input  logic [SIDE_W-1:0]                                    side_i,
  output logic                                                 vld_o,
  output evr_pkg::trig_t [evr_pkg::NUM_AXES-1:0]               trig_o,
  output logic [SIDE_W-1:0]                                    side_o
);
  import evr_pkg::*;

  trig_word_t                x_r    [0:CORDIC_STAGES][NUM_AXES];
  trig_word_t                y_r    [0:CORDIC_STAGES][NUM_AXES];
  trig_word_t                z_r    [0:CORDIC_STAGES][NUM_AXES];
  logic [NUM_AXES-1:0]       flip_r [0:CORDIC_STAGES];
  logic [SIDE_W-1:0]         side_r [0:CORDIC_STAGES];
  logic [CORDIC_STAGES:0]    vld_r;

  trig_word_t                a32    [NUM_AXES];
  trig_word_t                z0     [NUM_AXES];
  logic [NUM_AXES-1:0]       flip;

  trig_t [NUM_AXES-1:0]      trig_r;
  logic [SIDE_W-1:0]         side_out_r;
  logic                      vld_out_r;

  // fold the angle into [-pi/2, pi/2]
  always_comb begin
    for (int l = 0; l < NUM_AXES; l++) begin
      a32[l]  = trig_word_t'(angle_i[l]) <<< (TRIG_W - ANGLE_WIDTH);
      flip[l] = (a32[l] > HALF_PI) || (a32[l] < NEG_HALF_PI);
      z0[l]   = flip[l] ? {~a32[l][TRIG_W-1], a32[l][TRIG_W-2:0]} : a32[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      flip_r[0] <= flip;
      for (int l = 0; l < NUM_AXES; l++) begin
        x_r[0][l] <= GAIN_Q30;
        y_r[0][l] <= '0;
        z_r[0][l] <= z0[l];
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    trig_word_t x_nxt [NUM_AXES];
    trig_word_t y_nxt [NUM_AXES];
    trig_word_t z_nxt [NUM_AXES];

    always_comb begin
      for (int l = 0; l < NUM_AXES; l++) begin
        if (!z_r[i][l][TRIG_W-1]) begin
          x_nxt[l] = x_r[i][l] - (y_r[i][l] >>> i);
          y_nxt[l] = y_r[i][l] + (x_r[i][l] >>> i);
          z_nxt[l] = z_r[i][l] - ATAN_TBL[i];
        end else begin
          x_nxt[l] = x_r[i][l] + (y_r[i][l] >>> i);
          y_nxt[l] = y_r[i][l] - (x_r[i][l] >>> i);
          z_nxt[l] = z_r[i][l] + ATAN_TBL[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i+1] <= side_r[i];
        flip_r[i+1] <= flip_r[i];
        for (int l = 0; l < NUM_AXES; l++) begin
          x_r[i+1][l] <= x_nxt[l];
          y_r[i+1][l] <= y_nxt[l];
          z_r[i+1][l] <= z_nxt[l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out_r <= 1'b0;
    end else if (en) begin
      vld_out_r <= vld_r[CORDIC_STAGES];
    end
  end

  // undo the fold by negating both results
  always_ff @(posedge clk) begin
    if (en) begin
      side_out_r <= side_r[CORDIC_STAGES];
      for (int l = 0; l < NUM_AXES; l++) begin
        trig_r[l].cos_v <= flip_r[CORDIC_STAGES][l] ? -x_r[CORDIC_STAGES][l]
                                                    :  x_r[CORDIC_STAGES][l];
        trig_r[l].sin_v <= flip_r[CORDIC_STAGES][l] ? -y_r[CORDIC_STAGES][l]
                                                    :  y_r[CORDIC_STAGES][l];
      end
    end
  end

  assign vld_o  = vld_out_r;
  assign trig_o = trig_r;
  assign side_o = side_out_r;

endmodule

// ----- rtl/core/evr_rot.sv -----
`timescale 1ns / 1ps
// Three-stage plane rotation with rounding and saturation.
module evr_rot #(
  parameter int COORD_WIDTH = 32,
  parameter int SIDE_W      = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic signed [COORD_WIDTH-1:0] a_i,
  input  logic signed [COORD_WIDTH-1:0] b_i,
  input  evr_pkg::trig_t                trig_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          vld_o,
  output logic signed [COORD_WIDTH-1:0] a_o,
  output logic signed [COORD_WIDTH-1:0] b_o,
  output logic [SIDE_W-1:0]             side_o
);
  import evr_pkg::*;

  localparam int LO_W  = COORD_WIDTH / 2;
  localparam int HI_W  = COORD_WIDTH - LO_W;
  localparam int PH_W  = HI_W + TRIG_W;
  localparam int PL_W  = LO_W + 1 + TRIG_W;
  localparam int SH_W  = PH_W + 1;
  localparam int SL_W  = PL_W + 1;
  localparam int ACC_W = COORD_WIDTH + 34;

  localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(1) <<< (FRAC_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX =
    (ACC_W'(1) <<< (COORD_WIDTH - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  logic signed [HI_W-1:0]    ah, bh;
  logic signed [LO_W:0]      al, bl;

  logic signed [PH_W-1:0]    hac_r, hbs_r, hbc_r, has_r;
  logic signed [PL_W-1:0]    lac_r, lbs_r, lbc_r, las_r;
  logic signed [SH_W-1:0]    ahi_r, bhi_r;
  logic signed [SL_W-1:0]    alo_r, blo_r;
  logic signed [ACC_W-1:0]   aacc, bacc;
  logic signed [COORD_WIDTH-1:0] a_r, b_r;

  logic [2:0]                vld_r;
  logic [SIDE_W-1:0]         side_r [3];

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W-1:0] q;
    q = acc >>> FRAC_SHIFT;
    if (q > SAT_MAX) begin
      return SAT_MAX[COORD_WIDTH-1:0];
    end else if (q < SAT_MIN) begin
      return SAT_MIN[COORD_WIDTH-1:0];
    end
    return q[COORD_WIDTH-1:0];
  endfunction

  assign ah = a_i[COORD_WIDTH-1:LO_W];
  assign bh = b_i[COORD_WIDTH-1:LO_W];
  assign al = {1'b0, a_i[LO_W-1:0]};
  assign bl = {1'b0, b_i[LO_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      side_r[1] <= side_r[0];
      side_r[2] <= side_r[1];

      hac_r <= ah * trig_i.cos_v;
      hbs_r <= bh * trig_i.sin_v;
      hbc_r <= bh * trig_i.cos_v;
      has_r <= ah * trig_i.sin_v;
      lac_r <= al * trig_i.cos_v;
      lbs_r <= bl * trig_i.sin_v;
      lbc_r <= bl * trig_i.cos_v;
      las_r <= al * trig_i.sin_v;

      ahi_r <= SH_W'(hac_r) + SH_W'(hbs_r);
      alo_r <= SL_W'(lac_r) + SL_W'(lbs_r);
      bhi_r <= SH_W'(hbc_r) - SH_W'(has_r);
      blo_r <= SL_W'(lbc_r) - SL_W'(las_r);

      a_r <= sat_coord(aacc);
      b_r <= sat_coord(bacc);
    end
  end

  assign aacc = (ACC_W'(ahi_r) <<< LO_W) + ACC_W'(alo_r) + ROUND_C;
  assign bacc = (ACC_W'(bhi_r) <<< LO_W) + ACC_W'(blo_r) + ROUND_C;

  assign vld_o  = vld_r[2];
  assign a_o    = a_r;
  assign b_o    = b_r;
  assign side_o = side_r[2];

endmodule

// ----- rtl/core/vec3_euler_rotation.sv -----
`timescale 1ns / 1ps
// Top level: Z-Y-X Euler rotation of a fixed-point 3D vector.
//
//  channel | direction | tdata fields (low bit first)
//  in_     | slave     | vec_x, vec_y, vec_z, angle_x, angle_y, angle_z
//  out_    | master    | rot_x, rot_y, rot_z
//
// Accepts one transaction per cycle while the output is not stalled; data runs
// through the sine/cosine pipeline, then the Z, Y and X plane rotations.
// One global enable moves all stages together; it drops while the output
// register holds a transaction that is not taken, freezing every stage.
// Reset clears the valid bits and the in-flight counter only.
module vec3_euler_rotation #(
  parameter int COORD_WIDTH   = 32,
  parameter int ANGLE_WIDTH   = 32,
  parameter int CORDIC_STAGES = 24
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // vec_x, vec_y, vec_z, angle_x, angle_y, angle_z, zero pad
  input  logic [((3*COORD_WIDTH+3*ANGLE_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  // rot_x, rot_y, rot_z, zero pad
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]            out_tdata
);
  import evr_pkg::*;

  localparam int OUT_TDATA_W = ((3*COORD_WIDTH+7)/8)*8;
  localparam int TRIG_BITS   = $bits(trig_t);
  localparam int LAT         = CORDIC_STAGES + 11;
  localparam int OCC_W       = $clog2(LAT + 2);

  logic en;

  logic signed [COORD_WIDTH-1:0] vec_x, vec_y, vec_z;
  logic [NUM_AXES-1:0][ANGLE_WIDTH-1:0] angles;

  logic                          cd_vld;
  trig_t [NUM_AXES-1:0]          cd_trig;
  logic [3*COORD_WIDTH-1:0]      cd_side;
  logic signed [COORD_WIDTH-1:0] cd_x, cd_y, cd_z;

  logic                          rz_vld;
  logic signed [COORD_WIDTH-1:0] rz_x, rz_y, rz_z;
  trig_t                         rz_ty, rz_tx;
  logic [COORD_WIDTH+2*TRIG_BITS-1:0] rz_side;

  logic                          ry_vld;
  logic signed [COORD_WIDTH-1:0] ry_x, ry_y, ry_z;
  trig_t                         ry_tx;
  logic [COORD_WIDTH+TRIG_BITS-1:0] ry_side;

  logic                          rx_vld;
  logic signed [COORD_WIDTH-1:0] rx_x, rx_y, rx_z;

  logic [OCC_W-1:0]              occ_r;
  logic                          trig_in_range;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en && rst_n;

  assign vec_x          = in_tdata[0 +: COORD_WIDTH];
  assign vec_y          = in_tdata[COORD_WIDTH +: COORD_WIDTH];
  assign vec_z          = in_tdata[2*COORD_WIDTH +: COORD_WIDTH];
  assign angles[AXIS_X] = in_tdata[3*COORD_WIDTH +: ANGLE_WIDTH];
  assign angles[AXIS_Y] = in_tdata[3*COORD_WIDTH+ANGLE_WIDTH +: ANGLE_WIDTH];
  assign angles[AXIS_Z] = in_tdata[3*COORD_WIDTH+2*ANGLE_WIDTH +: ANGLE_WIDTH];

  evr_cordic #(
    .ANGLE_WIDTH   (ANGLE_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES),
    .SIDE_W        (3*COORD_WIDTH)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (in_tvalid),
    .angle_i (angles),
    .side_i  ({vec_z, vec_y, vec_x}),
    .vld_o   (cd_vld),
    .trig_o  (cd_trig),
    .side_o  (cd_side)
  );

  assign {cd_z, cd_y, cd_x} = cd_side;

  evr_rot #(
    .COORD_WIDTH (COORD_WIDTH),
    .SIDE_W      (COORD_WIDTH + 2*TRIG_BITS)
  ) u_rot_z (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (cd_vld),
    .a_i    (cd_x),
    .b_i    (cd_y),
    .trig_i (cd_trig[AXIS_Z]),
    .side_i ({cd_z, cd_trig[AXIS_Y], cd_trig[AXIS_X]}),
    .vld_o  (rz_vld),
    .a_o    (rz_x),
    .b_o    (rz_y),
    .side_o (rz_side)
  );

  assign {rz_z, rz_ty, rz_tx} = rz_side;

  evr_rot #(
    .COORD_WIDTH (COORD_WIDTH),
    .SIDE_W      (COORD_WIDTH + TRIG_BITS)
  ) u_rot_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (rz_vld),
    .a_i    (rz_z),
    .b_i    (rz_x),
    .trig_i (rz_ty),
    .side_i ({rz_y, rz_tx}),
    .vld_o  (ry_vld),
    .a_o    (ry_z),
    .b_o    (ry_x),
    .side_o (ry_side)
  );

  assign {ry_y, ry_tx} = ry_side;

  evr_rot #(
    .COORD_WIDTH (COORD_WIDTH),
    .SIDE_W      (COORD_WIDTH)
  ) u_rot_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (ry_vld),
    .a_i    (ry_y),
    .b_i    (ry_z),
    .trig_i (ry_tx),
    .side_i (ry_x),
    .vld_o  (rx_vld),
    .a_o    (rx_y),
    .b_o    (rx_z),
    .side_o (rx_x)
  );

  assign out_tvalid = rx_vld;
  assign out_tdata  = OUT_TDATA_W'({rx_z, rx_y, rx_x});

  // track transactions in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_r + OCC_W'(in_tvalid && in_tready) - OCC_W'(out_tvalid && out_tready);
    end
  end

  always_comb begin
    trig_in_range = 1'b1;
    for (int l = 0; l < NUM_AXES; l++) begin
      if (cd_trig[l].cos_v > TRIG_BOUND || cd_trig[l].cos_v < -TRIG_BOUND ||
          cd_trig[l].sin_v > TRIG_BOUND || cd_trig[l].sin_v < -TRIG_BOUND) begin
        trig_in_range = 1'b0;
      end
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(LAT))
    else $error("more transactions in flight than pipeline stages");

  a_out_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> occ_r != '0)
    else $error("output valid with no transaction in flight");

  a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
    cd_vld |-> trig_in_range)
    else $error("sine or cosine outside unit range");

endmodule

// ----- dv/vec3_euler_rotation_checker.sv -----
`timescale 1ns / 1ps
// Checker for the Z-Y-X Euler rotation: predicts each rotated vector and compares.
module vec3_euler_rotation_checker #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  // vec_x, vec_y, vec_z, angle_x, angle_y, angle_z
  input  logic [5:0][31:0] in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  // rot_x, rot_y, rot_z
  input  logic [2:0][31:0] out_tdata,
  output int               mismatches,
  output int               outstanding
);
  import evr_pkg::*;

  localparam longint PI_UNITS = 64'sh8000_0000;
  localparam longint COORD_HI = 64'sh7FFF_FFFF;
  localparam longint COORD_LO = -64'sh8000_0000;

  typedef logic [2:0][31:0] rot_vec_t;

  rot_vec_t rotated_q[$];
  int       fail_cnt = 0;
  string    axis_name[3] = '{"rot_x", "rot_y", "rot_z"};

  function automatic void trig_of(input logic [31:0] ang, output longint cv,
                                  output longint sv);
    longint x, y, z, dx, dy;
    bit     flip;
    z    = $signed(ang);
    x    = GAIN_Q30;
    y    = 0;
    flip = 1'b0;
    if (z > HALF_PI) begin
      z    = z - PI_UNITS;
      flip = 1'b1;
    end else if (z < NEG_HALF_PI) begin
      z    = z + PI_UNITS;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STAGES && i < ATAN_ENTRIES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TBL[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TBL[i];
      end
    end
    cv = flip ? -x : x;
    sv = flip ? -y : y;
  endfunction

  // round((a*c + b*s) / 2^30), half toward +inf, then clamp
  function automatic longint blend(input longint a, input longint b, input longint c,
                                   input longint s);
    logic signed [95:0] acc;
    acc = a * c + b * s;
    acc = (acc + (96'sd1 <<< 29)) >>> 30;
    if (acc > COORD_HI) return COORD_HI;
    if (acc < COORD_LO) return COORD_LO;
    return acc[63:0];
  endfunction

  function automatic rot_vec_t euler_rotate(input logic [5:0][31:0] item);
    longint   p[3];
    longint   c, s, a, b;
    rot_vec_t res;
    p[AXIS_X] = $signed(item[0]);
    p[AXIS_Y] = $signed(item[1]);
    p[AXIS_Z] = $signed(item[2]);

    trig_of(item[5], c, s);
    a = blend(p[AXIS_X], p[AXIS_Y], c, s);
    b = blend(p[AXIS_Y], p[AXIS_X], c, -s);
    p[AXIS_X] = a;
    p[AXIS_Y] = b;

    trig_of(item[4], c, s);
    a = blend(p[AXIS_X], p[AXIS_Z], c, -s);
    b = blend(p[AXIS_Z], p[AXIS_X], c, s);
    p[AXIS_X] = a;
    p[AXIS_Z] = b;

    trig_of(item[3], c, s);
    a = blend(p[AXIS_Y], p[AXIS_Z], c, s);
    b = blend(p[AXIS_Z], p[AXIS_Y], c, -s);
    p[AXIS_Y] = a;
    p[AXIS_Z] = b;

    for (int k = 0; k < NUM_AXES; k++) res[k] = p[k][31:0];
    return res;
  endfunction

  always @(posedge clk) begin
    rot_vec_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) rotated_q.push_back(euler_rotate(in_tdata));
      if (out_tvalid && out_tready) begin
        if (rotated_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual %h", $time, out_tdata);
          fail_cnt++;
        end else begin
          want = rotated_q.pop_front();
          for (int k = 0; k < NUM_AXES; k++) begin
            if (out_tdata[k] !== want[k]) begin
              $display("%0t: %s mismatch, expected %h, actual %h", $time, axis_name[k],
                       want[k], out_tdata[k]);
              fail_cnt++;
            end
          end
        end
      end
    end
    mismatches  <= fail_cnt;
    outstanding <= rotated_q.size();
  end

endmodule

// ----- dv/tb_vec3_euler_rotation.sv -----
`timescale 1ns / 1ps
// Testbench top: drives vectors and angles into the Euler rotation block and reports the verdict.
module tb_vec3_euler_rotation;

  localparam int CORDIC_STAGES   = 24;
  localparam int LATENCY         = CORDIC_STAGES + 11;
  localparam int QUIET_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 515;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [191:0] in_tdata   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;

  int snd_gap_pct   = 6;
  int rcv_stall_pct = 59;
  int quiet_cycles  = 0;
  int mismatches;
  int outstanding;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vec3_euler_rotation #(
    .COORD_WIDTH  (32),
    .ANGLE_WIDTH  (32),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  vec3_euler_rotation_checker #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) rot_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0001_0000;
      5:       return 32'($urandom_range(1 << 25) - (1 << 24));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_angle();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'h4000_0000;
      2:       return 32'hC000_0000;
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      5:       return 32'h4000_0000 + $urandom_range(4) - 2;
      6:       return 32'hC000_0000 + $urandom_range(4) - 2;
      default: return 32'h8000_0000 + $urandom_range(3);
    endcase
  endfunction

  task automatic push_vector(input logic [31:0] vx, input logic [31:0] vy,
                             input logic [31:0] vz, input logic [31:0] ax,
                             input logic [31:0] ay, input logic [31:0] az);
    while ($urandom_range(99) < snd_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {az, ay, ax, vz, vy, vx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic random_vector();
    logic [31:0] v[3];
    logic [31:0] ang[3];
    int          kind;
    int          keep;
    kind = $urandom_range(9);
    keep = $urandom_range(2);
    for (int k = 0; k < 3; k++) begin
      if (kind < 4) v[k] = $urandom();
      else if (kind < 7) v[k] = 32'($urandom_range(1 << 25) - (1 << 24));
      else v[k] = pick_coord();
      ang[k] = (kind == 6 || kind == 9) ? pick_angle() : $urandom();
      if (kind == 8 && k != keep) ang[k] = '0;
    end
    push_vector(v[0], v[1], v[2], ang[0], ang[1], ang[2]);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    push_vector(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_vector(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h4000_0000);
    push_vector(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'hC000_0000);
    push_vector(32'h0, 32'h0001_0000, 32'h0, 32'h8000_0000, 32'h0, 32'h0);
    push_vector(32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h7FFF_FFFF, 32'h0);
    push_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h2000_0000);
    push_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h2000_0000, 32'h0);
    push_vector(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hE000_0000, 32'h0, 32'h0);
    push_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
    push_vector(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'h4000_0001, 32'hBFFF_FFFF, 32'h3FFF_FFFF);
    push_vector(32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
                32'hC000_0001, 32'h4000_0000, 32'h0000_0001);
    push_vector(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                32'h1555_5555, 32'hEAAA_AAAB, 32'h2AAA_AAAA);
    push_vector(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000,
                32'h8000_0001, 32'h8000_0001, 32'h8000_0001);
    push_vector(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_vector(32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9,
                32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h3C3C_3C3C);

    for (int ph = 0; ph < 3; ph++) begin
      snd_gap_pct   <= (ph == 0) ? 6 : (ph == 1) ? 59 : 0;
      rcv_stall_pct <= (ph == 0) ? 59 : (ph == 1) ? 6 : 0;
      repeat (ITEMS_PER_PHASE) random_vector();
      in_tvalid <= 1'b0;
      @(posedge clk);
      while (outstanding != 0) @(posedge clk);
    end

    repeat (LATENCY + 16) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/evr_pkg.sv
rtl/core/evr_cordic.sv
rtl/core/evr_rot.sv
rtl/core/vec3_euler_rotation.sv
dv/vec3_euler_rotation_checker.sv
dv/tb_vec3_euler_rotation.sv
